FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the point-in-polygon block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define PIP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("pip assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define PIP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pip assertion failed");

`endif

FILE: rtl/pip_pkg.sv
// Shared opcodes and constants of the point-in-polygon block.
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  // Register stages between an edge request and its parity toggle.
  localparam int EDGE_LATENCY = 3;
  localparam int DRAIN_W      = $clog2(EDGE_LATENCY + 1);

endpackage
`default_nettype wire

FILE: rtl/point_in_polygon_test_core.sv
// Top level of the even-odd ray-casting point-in-polygon test.
//
// The input channel (in_valid/in_ready) carries one transaction per command:
// clear empties the polygon, append stores one corner (dropped and flagged
// as overflow once MAX_CORNERS are held), test queries a point. Opcode 3 is
// ignored. Only a test produces a transaction on the output channel
// (out_valid/out_ready), carrying the parity result and the overflow flag.
// Clear and append complete while the block stays idle. A test rotates the
// corner chain once, one corner per cycle, feeding a three-stage edge
// evaluator, then waits in the drain state until the evaluator has emptied
// before the parity result is registered for the output channel.
// The block works on one command at a time; while a result waits for
// out_ready, further commands are held off until it is taken, and a stalled
// receiver simply keeps the result valid and stable.
// A synchronous active-low reset empties the polygon and clears the overflow
// flag; corner storage itself is not cleared, as unwritten corners are never
// read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module point_in_polygon_test_core #(
  parameter int MAX_CORNERS = 64,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_opcode,
  input  wire logic [COORD_WIDTH-1:0] in_coord_x,
  input  wire logic [COORD_WIDTH-1:0] in_coord_y,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_inside_res,
  output logic                        out_overflowed
);

  localparam int CNT_W = $clog2(MAX_CORNERS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN} state_t;

  state_t                        state_r;
  logic [CNT_W-1:0]              count_r, step_r;
  logic                          ovf_r, parity_r;
  logic [pip_pkg::DRAIN_W-1:0]   drain_r;
  logic [COORD_WIDTH-1:0]        px_r, py_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                          out_valid_r, out_inside_r, out_ovf_r;

  logic                          in_fire, append_fire, shift, eval_v, closing;
  logic [COORD_WIDTH-1:0]        ei_x, ei_y;
  logic                          tog_valid, tog;

  logic [COORD_WIDTH-1:0] cx [MAX_CORNERS];
  logic [COORD_WIDTH-1:0] cy [MAX_CORNERS];

  // New commands are taken only when idle and the output register is free
  // or being emptied in this cycle.
  assign in_ready    = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire     = in_valid && in_ready;
  assign append_fire = in_fire && (in_opcode == pip_pkg::OP_APPEND);

  // The chain rotates towards cell zero, so the head presents corner step_r.
  assign shift   = (state_r == ST_WALK) && (step_r != CNT_W'(MAX_CORNERS));
  assign closing = (step_r == count_r) && (count_r != '0);
  assign eval_v  = (state_r == ST_WALK) &&
                   (((step_r != '0) && (step_r < count_r)) || closing);
  // The closing edge pairs the first corner with the last one.
  assign ei_x    = closing ? first_x_r : cx[0];
  assign ei_y    = closing ? first_y_r : cy[0];

  for (genvar k = 0; k < MAX_CORNERS; k++) begin : g_cell
    pip_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
      .clk   (clk),
      .load  (append_fire && (count_r == CNT_W'(k))),
      .shift (shift),
      .ld_x  (in_coord_x),
      .ld_y  (in_coord_y),
      .nb_x  (cx[(k + 1) % MAX_CORNERS]),
      .nb_y  (cy[(k + 1) % MAX_CORNERS]),
      .q_x   (cx[k]),
      .q_y   (cy[k])
    );
  end

  pip_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (eval_v),
    .xi        (ei_x),
    .yi        (ei_y),
    .xj        (prev_x_r),
    .yj        (prev_y_r),
    .px        (px_r),
    .py        (py_r),
    .tog_valid (tog_valid),
    .tog       (tog)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      drain_r     <= '0;
      parity_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (tog_valid && tog) begin
        parity_r <= !parity_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_opcode)
              pip_pkg::OP_CLEAR: begin
                count_r <= '0;
                ovf_r   <= 1'b0;
              end
              pip_pkg::OP_APPEND: begin
                if (count_r < CNT_W'(MAX_CORNERS)) begin
                  count_r <= count_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              pip_pkg::OP_TEST: begin
                px_r     <= in_coord_x;
                py_r     <= in_coord_y;
                step_r   <= '0;
                parity_r <= 1'b0;
                state_r  <= ST_WALK;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (shift) begin
            prev_x_r <= cx[0];
            prev_y_r <= cy[0];
            if (step_r == '0) begin
              first_x_r <= cx[0];
              first_y_r <= cy[0];
            end
            step_r <= step_r + 1'b1;
          end else begin
            drain_r <= '0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_r == pip_pkg::DRAIN_W'(pip_pkg::EDGE_LATENCY)) begin
            out_valid_r  <= 1'b1;
            out_inside_r <= parity_r;
            out_ovf_r    <= ovf_r;
            state_r      <= ST_IDLE;
          end else begin
            drain_r <= drain_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_overflowed = out_ovf_r;

  `PIP_ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(MAX_CORNERS))
  `PIP_ASSERT_IMPLIES(a_ovf_full, ovf_r, count_r == CNT_W'(MAX_CORNERS))
  `PIP_ASSERT_IMPLIES(a_edge_idle, tog_valid && (state_r == ST_IDLE), 1'b0)

endmodule
`default_nettype wire

FILE: rtl/pip_cell.sv
// One corner cell of the rotating corner chain.
`timescale 1ns / 1ps
`default_nettype none
module pip_cell #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   load,
  input  wire logic                   shift,
  input  wire logic [COORD_WIDTH-1:0] ld_x,
  input  wire logic [COORD_WIDTH-1:0] ld_y,
  input  wire logic [COORD_WIDTH-1:0] nb_x,
  input  wire logic [COORD_WIDTH-1:0] nb_y,
  output logic      [COORD_WIDTH-1:0] q_x,
  output logic      [COORD_WIDTH-1:0] q_y
);

  logic [COORD_WIDTH-1:0] x_r, y_r;

  // A load and a shift never coincide, as appends only happen while idle.
  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= ld_x;
      y_r <= ld_y;
    end else if (shift) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end
  end

  assign q_x = x_r;
  assign q_y = y_r;

endmodule
`default_nettype wire

FILE: rtl/pip_edge.sv
// Pipelined edge evaluator: decides whether one edge toggles the parity.
`timescale 1ns / 1ps
`default_nettype none
module pip_edge #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   req_valid,
  input  wire logic [COORD_WIDTH-1:0] xi,
  input  wire logic [COORD_WIDTH-1:0] yi,
  input  wire logic [COORD_WIDTH-1:0] xj,
  input  wire logic [COORD_WIDTH-1:0] yj,
  input  wire logic [COORD_WIDTH-1:0] px,
  input  wire logic [COORD_WIDTH-1:0] py,
  output logic                        tog_valid,
  output logic                        tog
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] sxi, syi, sxj, syj, spx, spy;
  logic                          straddle, left_end, en_nxt;
  logic signed [DW-1:0]          dpy_nxt, dx_nxt, dpx_nxt, d_nxt;

  logic                 a_valid_r, a_en_r, a_dpos_r;
  logic signed [DW-1:0] a_dpy_r, a_dx_r, a_dpx_r, a_d_r;
  logic                 b_valid_r, b_en_r, b_dpos_r;
  logic signed [PW-1:0] b_lhs_r, b_rhs_r;
  logic                 tog_valid_r, tog_r;

  always_comb begin
    sxi = $signed(xi);
    syi = $signed(yi);
    sxj = $signed(xj);
    syj = $signed(yj);
    spx = $signed(px);
    spy = $signed(py);
    straddle = ((syi < spy) && (syj >= spy)) || ((syj < spy) && (syi >= spy));
    left_end = (sxi <= spx) || (sxj <= spx);
    en_nxt   = straddle && left_end;
    dpy_nxt  = DW'(spy) - DW'(syi);
    dx_nxt   = DW'(sxj) - DW'(sxi);
    dpx_nxt  = DW'(spx) - DW'(sxi);
    d_nxt    = DW'(syj) - DW'(syi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      tog_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= req_valid;
      b_valid_r   <= a_valid_r;
      tog_valid_r <= b_valid_r;
    end
    // Stage one: differences and the straddle test.
    a_en_r   <= en_nxt;
    a_dpos_r <= (d_nxt > 0);
    a_dpy_r  <= dpy_nxt;
    a_dx_r   <= dx_nxt;
    a_dpx_r  <= dpx_nxt;
    a_d_r    <= d_nxt;
    // Stage two: the two exact cross products.
    b_en_r   <= a_en_r;
    b_dpos_r <= a_dpos_r;
    b_lhs_r  <= PW'(a_dpy_r) * PW'(a_dx_r);
    b_rhs_r  <= PW'(a_dpx_r) * PW'(a_d_r);
    // Stage three: the crossing lies strictly left of the point.
    tog_r    <= b_en_r && (b_dpos_r ? (b_lhs_r < b_rhs_r) : (b_rhs_r < b_lhs_r));
  end

  assign tog_valid = tog_valid_r;
  assign tog       = tog_r;

endmodule
`default_nettype wire
